// ===== sv/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Types shared by the extended gcd block.
// ----------------------------------------------------------------------------
package egcd_pkg;

    typedef struct packed {
        logic signed [63:0] first_operand;
        logic signed [63:0] second_operand;
    } egcd_in_t;

    typedef struct packed {
        logic        [62:0] divisor_out;
        logic signed [63:0] coef_first;
        logic signed [63:0] coef_second;
    } egcd_out_t;

endpackage

// ===== sv/egcd_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_divider
// Bit-serial restoring divider, truncating signed quotient and remainder.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module egcd_divider
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] num,
    input  logic [DATA_WIDTH-1:0] den,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quo,
    output logic [DATA_WIDTH-1:0] rem
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH:0]   r_reg, r_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic                  qn_reg, qn_next, rn_reg, rn_next;
    logic                  done_reg, done_next;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;

    assign trial = {r_reg[DATA_WIDTH-1:0], q_reg[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        qn_next   = qn_reg;
        rn_next   = rn_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DATA_WIDTH);
            q_next    = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
            d_next    = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
            r_next    = '0;
            qn_next   = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            rn_next   = num[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            if (diff[DATA_WIDTH])
            begin
                r_next = trial;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                r_next = diff;
                q_next = {q_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        r_reg  <= r_next;
        d_reg  <= d_next;
        qn_reg <= qn_next;
        rn_reg <= rn_next;
    end

    assign done = done_reg;
    assign quo  = qn_reg ? (~q_reg + 1'b1) : q_reg;
    assign rem  = rn_reg ? (~r_reg[DATA_WIDTH-1:0] + 1'b1) : r_reg[DATA_WIDTH-1:0];
endmodule

// ===== sv/egcd_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_mac
// Bit-serial products q*s1 and q*t1 for the two coefficient rows.
// Shift-and-add over the bits of q, one bit per cycle, modulo 2^DATA_WIDTH.
// ----------------------------------------------------------------------------
module egcd_mac
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] q,
    input  logic [DATA_WIDTH-1:0] s1,
    input  logic [DATA_WIDTH-1:0] t1,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] sp,
    output logic [DATA_WIDTH-1:0] tp
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic [DATA_WIDTH-1:0] ms_reg, ms_next, mt_reg, mt_next;
    logic [DATA_WIDTH-1:0] as_reg, as_next, at_reg, at_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        ms_next   = ms_reg;
        mt_next   = mt_reg;
        as_next   = as_reg;
        at_next   = at_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DATA_WIDTH);
            q_next    = q;
            ms_next   = s1;
            mt_next   = t1;
            as_next   = '0;
            at_next   = '0;
        end
        else if (busy_reg)
        begin
            if (q_reg[0])
            begin
                as_next = as_reg + ms_reg;
                at_next = at_reg + mt_reg;
            end
            q_next   = q_reg >> 1;
            ms_next  = ms_reg << 1;
            mt_next  = mt_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        ms_reg <= ms_next;
        mt_reg <= mt_next;
        as_reg <= as_next;
        at_reg <= at_next;
    end

    assign done = done_reg;
    assign sp   = as_reg;
    assign tp   = at_reg;
endmodule

// ===== sv/extended_gcd_bezout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_bezout
// Extended Euclid: gcd and Bezout coefficients of two signed integers.
// ----------------------------------------------------------------------------
// One transaction at a time. Each Euclid step runs a bit-serial division
// and then a bit-serial coefficient update, followed by the loop test in
// S_FIN. Up to roughly 92 steps are needed at 64 bits, far fewer for
// typical operands. The result sits in an output register; the next input
// is taken once it has been delivered.
module extended_gcd_bezout
    import egcd_pkg::*;
#(
    parameter int DATA_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  egcd_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output egcd_out_t out_data
);
    localparam int W = DATA_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MAC  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0] s0_reg, s0_next, s1_reg, s1_next;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next;
    egcd_out_t    res_reg, res_next;

    logic         div_start, div_done, mac_start, mac_done;
    logic [W-1:0] div_q, div_r, mac_s, mac_t;
    logic [W-1:0] g_abs, u_fix, v_fix;

    egcd_divider #(.DATA_WIDTH(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(r0_reg), .den(r1_reg),
        .done(div_done), .quo(div_q), .rem(div_r)
    );

    // quotient is taken straight from the divider while its done is high
    egcd_mac #(.DATA_WIDTH(W)) u_mac (
        .clk(clk), .rst_n(rst_n), .start(mac_start), .q(div_q), .s1(s1_reg),
        .t1(t1_reg), .done(mac_done), .sp(mac_s), .tp(mac_t)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    assign g_abs = r0_reg[W-1] ? (~r0_reg + 1'b1) : r0_reg;
    assign u_fix = r0_reg[W-1] ? (~s0_reg + 1'b1) : s0_reg;
    assign v_fix = r0_reg[W-1] ? (~t0_reg + 1'b1) : t0_reg;

    always_comb
    begin
        state_next = state_reg;
        r0_next = r0_reg; r1_next = r1_reg;
        s0_next = s0_reg; s1_next = s1_reg;
        t0_next = t0_reg; t1_next = t1_reg;
        res_next = res_reg;
        div_start = 1'b0;
        mac_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    r0_next = in_data.first_operand[W-1:0];
                    r1_next = in_data.second_operand[W-1:0];
                    s0_next = W'(1); s1_next = '0;
                    t0_next = '0;    t1_next = W'(1);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // r1 == 0 also covers gcd(0,0): r0=0, s0=1 would be wrong,
                // so zero inputs force zero coefficients.
                if (r1_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_next.divisor_out = 63'(64'(g_abs));
                    if (r0_reg == '0)
                    begin
                        res_next.coef_first  = '0;
                        res_next.coef_second = '0;
                    end
                    else
                    begin
                        res_next.coef_first  = {{(65-W){u_fix[W-1]}}, u_fix[W-2:0]};
                        res_next.coef_second = {{(65-W){v_fix[W-1]}}, v_fix[W-2:0]};
                    end
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    r0_next = r1_reg;
                    r1_next = div_r;
                    mac_start  = 1'b1;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    s0_next = s1_reg; s1_next = s0_reg - mac_s;
                    t0_next = t1_reg; t1_next = t0_reg - mac_t;
                    state_next = S_FIN;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        r0_reg <= r0_next; r1_reg <= r1_next;
        s0_reg <= s0_next; s1_reg <= s1_next;
        t0_reg <= t0_next; t1_reg <= t1_next;
        res_reg <= res_next;
    end
endmodule

// ===== dv/tb_extended_gcd_bezout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_extended_gcd_bezout
// Self-checking bench for the extended gcd / Bezout block.
// ----------------------------------------------------------------------------
// A directed table (zeros, units, extremes, signs, most negative value) is
// followed by random operand pairs of mixed magnitude. Each result is
// compared field by field against a typed-in value or a local Euclid
// predictor. The sender idles in bursts; the receiver stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_extended_gcd_bezout;
    import egcd_pkg::*;

    localparam int W         = 64;
    localparam int N_RANDOM  = 80;
    localparam int N_DIRECT  = 20;
    localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    egcd_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    egcd_out_t out_data;

    egcd_out_t expected_q[$];
    int        n_mismatch;
    bit        stim_done;

    typedef struct {
        logic [63:0] a;
        logic [63:0] b;
        bit          known;
        egcd_out_t   res;
    } vec_t;

    vec_t vecs[N_DIRECT];

    extended_gcd_bezout #(.DATA_WIDTH(W)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // truncating signed division at 64 bits, min / -1 wraps
    function automatic logic [63:0] quot_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        if (md == 0)
            return 64'd0;
        q = mn / md;
        if (n[63] != d[63])
            q = -q;
        return q;
    endfunction

    function automatic egcd_out_t bezout_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] r0, r1, s0, s1, t0, t1, q, nx;
        egcd_out_t   res;
        r0 = a; r1 = b;
        s0 = 64'd1; s1 = 64'd0;
        t0 = 64'd0; t1 = 64'd1;
        res = '0;
        if (a == 0 && b == 0)
            return res;
        while (r1 != 0)
        begin
            q = quot_trunc(r0, r1);
            nx = r0 - q * r1; r0 = r1; r1 = nx;
            nx = s0 - q * s1; s0 = s1; s1 = nx;
            nx = t0 - q * t1; t0 = t1; t1 = nx;
        end
        if (r0[63])
        begin
            r0 = -r0; s0 = -s0; t0 = -t0;
        end
        res.divisor_out = r0[62:0];
        res.coef_first  = s0;
        res.coef_second = t0;
        return res;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        int          sh;
        v  = {$urandom, $urandom};
        sh = $urandom_range(0, 63);
        case ($urandom_range(0, 3))
            0: v = v >> sh;                        // mixed magnitudes
            1: v = $signed(v) >>> sh;
            2: v = v;
            default: v = {{56{v[7]}}, v[7:0]};     // small values
        endcase
        if (v == MINN && $urandom_range(0, 1))
            v = MAXP;
        return v;
    endfunction

    function automatic egcd_out_t mk(logic [62:0] g, logic [63:0] u, logic [63:0] v);
        egcd_out_t r;
        r.divisor_out = g;
        r.coef_first  = u;
        r.coef_second = v;
        return r;
    endfunction

    task automatic send_pair(logic [63:0] a, logic [63:0] b, egcd_out_t exp_res);
        in_valid <= 1'b1;
        in_data.first_operand  <= a;
        in_data.second_operand <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(exp_res);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // directed rows: expected typed in where obvious, otherwise predicted
    initial
    begin
        vecs[0]  = '{64'd0, 64'd0, 1, mk(63'd0, 64'd0, 64'd0)};
        vecs[1]  = '{64'd5, 64'd0, 1, mk(63'd5, 64'd1, 64'd0)};
        vecs[2]  = '{64'd0, 64'd7, 1, mk(63'd7, 64'd0, 64'd1)};
        vecs[3]  = '{-64'd5, 64'd0, 1, mk(63'd5, -64'd1, 64'd0)};
        vecs[4]  = '{64'd0, -64'd7, 1, mk(63'd7, 64'd0, -64'd1)};
        vecs[5]  = '{MAXP, 64'd0, 1, mk(MAXP[62:0], 64'd1, 64'd0)};
        vecs[6]  = '{MINN, 64'd0, 1, mk(63'd0, -64'd1, 64'd0)};
        vecs[7]  = '{64'd1, 64'd1, 0, '0};
        vecs[8]  = '{MAXP, MAXP, 0, '0};
        vecs[9]  = '{MAXP, -MAXP, 0, '0};
        vecs[10] = '{MAXP, MAXP - 64'd1, 0, '0};
        vecs[11] = '{MINN, -64'd1, 0, '0};
        vecs[12] = '{MINN, MINN, 0, '0};
        vecs[13] = '{64'd240, 64'd46, 0, '0};
        vecs[14] = '{-64'd240, 64'd46, 0, '0};
        vecs[15] = '{64'd240, -64'd46, 0, '0};
        vecs[16] = '{-64'd240, -64'd46, 0, '0};
        // consecutive Fibonacci numbers: longest chain of Euclid steps
        vecs[17] = '{64'd7540113804746346429, 64'd4660046610375530309, 0, '0};
        vecs[18] = '{64'hFFFF_FFFF_FFFF_FFFF, MINN, 0, '0};
        vecs[19] = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 0, '0};
    end

    initial
    begin
        int          burst;
        logic [63:0] ra;
        logic [63:0] rb;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        stim_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECT; i++)
        begin
            if (vecs[i].known)
                send_pair(vecs[i].a, vecs[i].b, vecs[i].res);
            else
                send_pair(vecs[i].a, vecs[i].b, bezout_of(vecs[i].a, vecs[i].b));
            if ($urandom_range(0, 2) == 0)
                idle_gap();
        end
        burst = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (burst == 0)
            begin
                idle_gap();
                burst = $urandom_range(1, 8);
            end
            ra = rand_operand();
            rb = rand_operand();
            send_pair(ra, rb, bezout_of(ra, rb));
            burst--;
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall: random stretches, each either calm or busy with random stalls
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            int len;
            bit busy;
            len  = $urandom_range(20, 200);
            busy = $urandom_range(0, 1);
            repeat (len)
            begin
                @(posedge clk);
                out_stall <= busy ? ($urandom_range(0, 3) != 0) : 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        egcd_out_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result transaction %p", out_data);
            end
            else
            begin
                exp_res = expected_q.pop_front();
                if (out_data.divisor_out !== exp_res.divisor_out
                    || out_data.coef_first !== exp_res.coef_first
                    || out_data.coef_second !== exp_res.coef_second)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp g=%0d u=%0d v=%0d got g=%0d u=%0d v=%0d",
                                 exp_res.divisor_out, exp_res.coef_first,
                                 exp_res.coef_second, out_data.divisor_out,
                                 out_data.coef_first, out_data.coef_second);
                end
            end
        end
    end

    initial
    begin
        n_mismatch = 0;
        wait (stim_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: sized for 100 worst-case items plus stalls, many times over
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
